FILE: sv/fdtw_pkg.sv
// Shared types, codes and helpers of the device tree structure token walker.
package fdtw_pkg;

    localparam int WordW = 32;

    localparam logic [2:0] EV_CONSUMED = 3'd0;
    localparam logic [2:0] EV_BEGIN    = 3'd1;
    localparam logic [2:0] EV_END      = 3'd2;
    localparam logic [2:0] EV_PROP     = 3'd3;
    localparam logic [2:0] EV_TREE_END = 3'd4;
    localparam logic [2:0] EV_INVALID  = 3'd5;
    localparam logic [2:0] EV_IGNORED  = 3'd6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [WordW-1:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [WordW-1:0] TOK_END_NODE   = 32'd2;
    localparam logic [WordW-1:0] TOK_PROP       = 32'd3;
    localparam logic [WordW-1:0] TOK_END        = 32'd9;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [WordW-1:0] token_offset;
        logic [WordW-1:0] prop_size;
        logic [WordW-1:0] name_address;
        logic [WordW-1:0] payload_word;
        logic [1:0]       payload_kind;
        logic             payload_last;
        logic [WordW-1:0] bad_token;
    } result_t;

    function automatic logic has_zero_byte(input logic [WordW-1:0] w);
        return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
               (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
    endfunction

endpackage

FILE: sv/fdt_structure_token_walker_top.sv
// Top level of the flattened device tree structure token walker.
// The block takes one big-endian structure word per beat and returns exactly one
// result beat for it: a token event, a passed-on node name or property data word,
// a consumed mark, or an ignored mark while parsing is stopped. A word with the
// start flag in s_tuser restarts parsing at offset zero. One word is accepted every
// clock cycle unless a full result register holds the input register back; a word
// waits in the input register and then moves to the result register, where its
// result beat is offered on the master side until the master side is ready.
// The strings offset register is written through the cfg channel, which is always
// ready, and should be changed only while no beats are in flight.
module fdt_structure_token_walker_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,      // strings_offset
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,       // struct_word
    input  logic [0:0]   s_tuser,       // start_req
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,       // token_offset, prop_size, name_address,
                                        // payload_word, bad_token
    output logic [4:0]   m_tuser,       // event_res, payload_kind
    output logic         m_tlast        // payload_last
);

    logic              in_valid_reg;
    logic [31:0]       in_word_reg;
    logic              in_start_reg;
    logic [31:0]       strings_offset_reg;
    logic              out_ready;
    logic              advance;
    fdtw_pkg::result_t step_result;
    fdtw_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            strings_offset_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                strings_offset_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    fdtw_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .word           (in_word_reg),
        .start          (in_start_reg),
        .strings_offset (strings_offset_reg),
        .result         (step_result)
    );

    fdtw_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (step_result),
        .load_ready (out_ready),
        .valid      (m_tvalid),
        .take       (m_tready),
        .result_out (out_result)
    );

    assign m_tdata = {out_result.bad_token, out_result.payload_word,
                      out_result.name_address, out_result.prop_size,
                      out_result.token_offset};
    assign m_tuser = {out_result.payload_kind, out_result.event_res};
    assign m_tlast = out_result.payload_last;

`ifndef SYNTHESIS
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg)
        else $error("Input word lost while the result register was full.");

    a_last_has_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[4:3] != fdtw_pkg::KIND_NONE)
        else $error("Last flag set on a result without payload.");

    a_ignored_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == fdtw_pkg::EV_IGNORED
        |-> m_tuser[4:3] == fdtw_pkg::KIND_NONE && !m_tlast)
        else $error("Ignored word carries payload.");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("Processed word produced no result.");
`endif

endmodule

FILE: sv/fdtw_step.sv
// Token state machine that turns one structure word into one result.
module fdtw_step (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic [31:0]             word,
    input  logic                    start,
    input  logic [31:0]             strings_offset,
    output fdtw_pkg::result_t       result
);

    typedef enum logic [2:0] {
        PH_STOP,
        PH_TOKEN,
        PH_NAME,
        PH_PSIZE,
        PH_POFF,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [29:0] words_left_reg, words_left_next;
    logic [31:0] held_size_reg, held_size_next;
    logic [31:0] word_position_reg, word_position_next;
    logic [31:0] token_start_reg, token_start_next;
    logic [31:0] pos_cur;
    logic [32:0] size_round;

    always_comb begin
        phase_cur          = start ? PH_TOKEN : phase_reg;
        pos_cur            = start ? 32'd0 : word_position_reg;
        phase_next         = phase_cur;
        words_left_next    = words_left_reg;
        held_size_next     = held_size_reg;
        token_start_next   = token_start_reg;
        size_round         = {1'b0, held_size_reg} + 33'd3;
        result             = '0;
        result.event_res   = fdtw_pkg::EV_CONSUMED;
        result.payload_kind = fdtw_pkg::KIND_NONE;

        unique case (phase_cur)
            PH_TOKEN: begin
                token_start_next = pos_cur;
                if (word == fdtw_pkg::TOK_BEGIN_NODE) begin
                    result.event_res = fdtw_pkg::EV_BEGIN;
                    phase_next       = PH_NAME;
                end else if (word == fdtw_pkg::TOK_END_NODE) begin
                    result.event_res = fdtw_pkg::EV_END;
                end else if (word == fdtw_pkg::TOK_PROP) begin
                    phase_next = PH_PSIZE;
                end else if (word == fdtw_pkg::TOK_END) begin
                    result.event_res = fdtw_pkg::EV_TREE_END;
                    phase_next       = PH_STOP;
                end else begin
                    result.event_res = fdtw_pkg::EV_INVALID;
                    result.bad_token = word;
                    phase_next       = PH_STOP;
                end
            end
            PH_NAME: begin
                result.payload_word = word;
                result.payload_kind = fdtw_pkg::KIND_NAME;
                if (fdtw_pkg::has_zero_byte(word)) begin
                    result.payload_last = 1'b1;
                    phase_next          = PH_TOKEN;
                end
            end
            PH_PSIZE: begin
                held_size_next = word;
                phase_next     = PH_POFF;
            end
            PH_POFF: begin
                result.event_res    = fdtw_pkg::EV_PROP;
                result.prop_size    = held_size_reg;
                result.name_address = strings_offset + word;
                if (held_size_reg == 32'd0) begin
                    phase_next = PH_TOKEN;
                end else begin
                    words_left_next = size_round[31:2] - 30'd1;
                    phase_next      = PH_DATA;
                end
            end
            PH_DATA: begin
                result.payload_word = word;
                result.payload_kind = fdtw_pkg::KIND_DATA;
                if (words_left_reg == 30'd0) begin
                    result.payload_last = 1'b1;
                    phase_next          = PH_TOKEN;
                end else begin
                    words_left_next = words_left_reg - 30'd1;
                end
            end
            default: begin
                result.event_res = fdtw_pkg::EV_IGNORED;
                phase_next       = PH_STOP;
            end
        endcase

        word_position_next  = (result.event_res != fdtw_pkg::EV_IGNORED) ?
                              pos_cur + 32'd4 : pos_cur;
        result.token_offset = token_start_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_STOP;
            words_left_reg    <= '0;
            held_size_reg     <= '0;
            word_position_reg <= '0;
            token_start_reg   <= '0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            words_left_reg    <= words_left_next;
            held_size_reg     <= held_size_next;
            word_position_reg <= word_position_next;
            token_start_reg   <= token_start_next;
        end
    end

endmodule

FILE: sv/fdtw_out_stage.sv
// Result register that holds one finished result until the master side takes it.
module fdtw_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fdtw_pkg::result_t result_in,
    output logic              load_ready,
    output logic              valid,
    input  logic              take,
    output fdtw_pkg::result_t result_out
);

    logic              valid_reg;
    fdtw_pkg::result_t result_reg;

    assign load_ready = !valid_reg || take;
    assign valid      = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

endmodule

FILE: bench/tb_fdt_structure_token_walker_top.sv
// Self-checking testbench for the device tree structure token walker top level.
module tb_fdt_structure_token_walker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdtw_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_WORDS = 155;

    typedef enum logic [2:0] {
        WALK_STOP, WALK_TOKEN, WALK_NAME, WALK_SIZE, WALK_NAMEOFF, WALK_DATA
    } walk_phase_t;

    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic        typed;
        logic [2:0]  ev;
        logic [31:0] bad;
    } walk_row_t;

    localparam walk_row_t DIRECTED [28] = '{
        '{32'h0000_0001, 1'b0, 1'b1, EV_IGNORED,  32'h0},
        '{TOK_END,       1'b1, 1'b1, EV_TREE_END, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, EV_IGNORED,  32'h0},
        '{32'h0000_0004, 1'b1, 1'b1, EV_INVALID,  32'h4},
        '{32'h0000_0000, 1'b1, 1'b1, EV_INVALID,  32'h0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, EV_INVALID,  32'hFFFF_FFFF},
        '{TOK_BEGIN_NODE, 1'b1, 1'b1, EV_BEGIN,   32'h0},
        '{32'h6162_6300, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_PROP,      1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_PROP,      1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0010, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'hDEAD_BEEF, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_BEGIN_NODE, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h4142_4344, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h4100_0000, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_END_NODE,  1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_PROP,      1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h1234_5678, 1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{TOK_END_NODE,  1'b1, 1'b1, EV_END,      32'h0},
        '{TOK_END,       1'b0, 1'b0, EV_CONSUMED, 32'h0},
        '{32'h0000_0007, 1'b0, 1'b0, EV_CONSUMED, 32'h0}
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;

    fdt_structure_token_walker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Predictor state, mirrored from the walker's behavior.
    walk_phase_t walk = WALK_STOP;
    logic [29:0] data_words_left = '0;
    logic [31:0] size_hold = '0;
    logic [31:0] byte_pos = '0;
    logic [31:0] tok_start = '0;
    logic [31:0] str_off = '0;

    result_t expected_events [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int words_sent = 0;
    int events_checked = 0;
    int offset_writes = 0;
    int items_done = 0;
    int stall_cycles = 0;

    function automatic result_t walk_word(input logic [31:0] w, input logic st);
        result_t r;
        logic [32:0] ndw;
        r = '0;
        r.event_res = EV_CONSUMED;
        r.payload_kind = KIND_NONE;
        if (st) begin
            byte_pos = '0;
            walk = WALK_TOKEN;
        end
        case (walk)
            WALK_TOKEN: begin
                tok_start = byte_pos;
                if (w == TOK_BEGIN_NODE) begin
                    r.event_res = EV_BEGIN;
                    walk = WALK_NAME;
                end else if (w == TOK_END_NODE) begin
                    r.event_res = EV_END;
                end else if (w == TOK_PROP) begin
                    walk = WALK_SIZE;
                end else if (w == TOK_END) begin
                    r.event_res = EV_TREE_END;
                    walk = WALK_STOP;
                end else begin
                    r.event_res = EV_INVALID;
                    r.bad_token = w;
                    walk = WALK_STOP;
                end
            end
            WALK_NAME: begin
                r.payload_word = w;
                r.payload_kind = KIND_NAME;
                if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                    w[15:8] == 8'h00 || w[7:0] == 8'h00) begin
                    r.payload_last = 1'b1;
                    walk = WALK_TOKEN;
                end
            end
            WALK_SIZE: begin
                size_hold = w;
                walk = WALK_NAMEOFF;
            end
            WALK_NAMEOFF: begin
                ndw = ({1'b0, size_hold} + 33'd3) >> 2;
                r.event_res = EV_PROP;
                r.prop_size = size_hold;
                r.name_address = str_off + w;
                if (ndw == '0) begin
                    walk = WALK_TOKEN;
                end else begin
                    ndw = ndw - 33'd1;
                    data_words_left = ndw[29:0];
                    walk = WALK_DATA;
                end
            end
            WALK_DATA: begin
                r.payload_word = w;
                r.payload_kind = KIND_DATA;
                if (data_words_left == '0) begin
                    r.payload_last = 1'b1;
                    walk = WALK_TOKEN;
                end else begin
                    data_words_left = data_words_left - 30'd1;
                end
            end
            default: begin
                walk = WALK_STOP;
                r.event_res = EV_IGNORED;
            end
        endcase
        if (r.event_res != EV_IGNORED) begin
            byte_pos = byte_pos + 32'd4;
        end
        r.token_offset = tok_start;
        return r;
    endfunction

    task automatic compare_event(input result_t got, input result_t want);
        if (got.event_res !== want.event_res) begin
            errors++;
            $error("event_res expected %0d got %0d", want.event_res, got.event_res);
        end
        if (got.token_offset !== want.token_offset) begin
            errors++;
            $error("token_offset expected %h got %h", want.token_offset, got.token_offset);
        end
        if (got.prop_size !== want.prop_size) begin
            errors++;
            $error("prop_size expected %h got %h", want.prop_size, got.prop_size);
        end
        if (got.name_address !== want.name_address) begin
            errors++;
            $error("name_address expected %h got %h", want.name_address, got.name_address);
        end
        if (got.payload_word !== want.payload_word) begin
            errors++;
            $error("payload_word expected %h got %h", want.payload_word, got.payload_word);
        end
        if (got.payload_kind !== want.payload_kind) begin
            errors++;
            $error("payload_kind expected %0d got %0d", want.payload_kind, got.payload_kind);
        end
        if (got.payload_last !== want.payload_last) begin
            errors++;
            $error("payload_last expected %b got %b", want.payload_last, got.payload_last);
        end
        if (got.bad_token !== want.bad_token) begin
            errors++;
            $error("bad_token expected %h got %h", want.bad_token, got.bad_token);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_res    = m_tuser[2:0];
            got.payload_kind = m_tuser[4:3];
            got.payload_last = m_tlast;
            got.token_offset = m_tdata[31:0];
            got.prop_size    = m_tdata[63:32];
            got.name_address = m_tdata[95:64];
            got.payload_word = m_tdata[127:96];
            got.bad_token    = m_tdata[159:128];
            if (expected_events.size() == 0) begin
                errors++;
                $error("result beat with no expected event, event_res %0d", got.event_res);
            end else begin
                compare_event(got, expected_events.pop_front());
                events_checked++;
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(input logic [31:0] w, input logic st,
                             input logic typed = 1'b0, input result_t want = '0);
        result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= st;
        do @(posedge aclk); while (!s_tready);
        pred = walk_word(w, st);
        expected_events.push_back(typed ? want : pred);
        words_sent++;
        if (pred.event_res != EV_IGNORED) begin
            items_done++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_events.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_strings_offset(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        str_off = value;
        offset_writes++;
    endtask

    task automatic send_name();
        int extra;
        int pos;
        logic [31:0] w;
        extra = $urandom_range(2);
        repeat (extra) begin
            w = {8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                 8'($urandom_range(255, 1)), 8'($urandom_range(255, 1))};
            send_word(w, 1'b0);
        end
        w = $urandom;
        pos = $urandom_range(3);
        w[pos*8 +: 8] = 8'h00;
        send_word(w, 1'b0);
    endtask

    task automatic restart_tree();
        send_word(TOK_BEGIN_NODE, 1'b1);
        send_name();
    endtask

    task automatic random_tree(input int target);
        int pick;
        int nwords;
        int k;
        logic huge;
        logic cut;
        logic drained;
        logic [31:0] size;
        items_done = 0;
        drained = 1'b0;
        restart_tree();
        while (items_done < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_word(TOK_BEGIN_NODE, 1'b0);
                send_name();
            end else if (pick < 45) begin
                send_word(TOK_END_NODE, 1'b0);
            end else if (pick < 78) begin
                huge = ($urandom_range(19) == 0);
                size = huge ? 32'hFFFF_FFFF - 32'($urandom_range(3)) : 32'($urandom_range(16));
                send_word(TOK_PROP, 1'b0);
                send_word(size, 1'b0);
                send_word($urandom, 1'b0);
                nwords = huge ? 2 : int'((size + 32'd3) >> 2);
                cut = huge || (nwords > 1 && $urandom_range(7) == 0);
                if (cut && !huge) begin
                    nwords = 1;
                end
                for (k = 0; k < nwords; k++) begin
                    send_word($urandom, 1'b0);
                end
                if (cut) begin
                    restart_tree();
                end
            end else if (pick < 84) begin
                send_word(TOK_END, 1'b0);
                repeat ($urandom_range(3, 1)) send_word($urandom, 1'($urandom_range(7) == 0));
                restart_tree();
            end else if (pick < 92) begin
                send_word(pick < 88 ? $urandom : 32'd4, 1'($urandom_range(1)));
                restart_tree();
            end else begin
                restart_tree();
            end
            if (!drained && items_done >= target / 2) begin
                drain_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        result_t want;
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 85;
        write_strings_offset(32'hFFFF_FFF0);
        for (i = 0; i < $size(DIRECTED); i++) begin
            want = '0;
            want.event_res = DIRECTED[i].ev;
            want.bad_token = DIRECTED[i].bad;
            send_word(DIRECTED[i].word, DIRECTED[i].start, DIRECTED[i].typed, want);
        end

        write_strings_offset($urandom);
        random_tree(RANDOM_WORDS);

        send_idle_pct = 85;
        recv_idle_pct = 22;
        write_strings_offset(32'hFFFF_FFFF);
        random_tree(RANDOM_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_strings_offset(32'h0000_0000);
        random_tree(RANDOM_WORDS);

        drain_results();
        repeat (8) @(posedge aclk);
        if (expected_events.size() != 0) begin
            errors++;
            $error("%0d expected events never arrived", expected_events.size());
        end

        $display("Walked %0d structure words under %0d strings offset settings.",
                 words_sent, offset_writes);
        $display("Checked %0d event beats with %0d mismatches.", events_checked, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
